>>> design/adcrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcrd_pkg
// Shared types, codes and tables for the 12-bit ADC register device with its
// window comparator.
// ----------------------------------------------------------------------------
package adcrd_pkg;

  // Kinds of input transactions.
  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_STOP  = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  // Register pointer values.
  localparam logic [1:0] PTR_CONVERSION = 2'd0;
  localparam logic [1:0] PTR_CONFIG     = 2'd1;
  localparam logic [1:0] PTR_LOW_THRESH = 2'd2;
  localparam logic [1:0] PTR_HIGH_THRESH = 2'd3;

  // Config word bit positions.
  localparam int CFG_LATCH    = 2;
  localparam int CFG_POLARITY = 3;
  localparam int CFG_WINDOW   = 4;
  localparam int CFG_SINGLE   = 8;
  localparam int CFG_START    = 15;

  // Comparator queue codes (config bits 1..0).
  localparam logic [1:0] QUEUE_ONE  = 2'd0;
  localparam logic [1:0] QUEUE_TWO  = 2'd1;
  localparam logic [1:0] QUEUE_FOUR = 2'd2;
  localparam logic [1:0] QUEUE_OFF  = 2'd3;

  // Full-scale range codes (config bits 11..9).
  localparam logic [2:0] RANGE_6144 = 3'd0;
  localparam logic [2:0] RANGE_4096 = 3'd1;
  localparam logic [2:0] RANGE_2048 = 3'd2;
  localparam logic [2:0] RANGE_1024 = 3'd3;
  localparam logic [2:0] RANGE_512  = 3'd4;

  // Input multiplexer codes (config bits 14..12).
  localparam logic [2:0] MUX_A0_A1 = 3'd0;
  localparam logic [2:0] MUX_A0_A3 = 3'd1;
  localparam logic [2:0] MUX_A1_A3 = 3'd2;
  localparam logic [2:0] MUX_A2_A3 = 3'd3;
  localparam logic [2:0] MUX_A0    = 3'd4;
  localparam logic [2:0] MUX_A1    = 3'd5;
  localparam logic [2:0] MUX_A2    = 3'd6;

  // Reset values of the register file.
  localparam logic [15:0] CONFIG_RESET    = 16'h8583;
  localparam logic [15:0] LOW_THR_RESET   = 16'h8000;
  localparam logic [15:0] HIGH_THR_RESET  = 16'h7fff;

  // Reciprocal of three in 2^-14 units; exact for magnitudes up to 6144.
  localparam logic [12:0] RECIP_THIRD = 13'd5462;

  // Bus phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_STARTED = 4'b0010,
    PH_HIGH    = 4'b0100,
    PH_LOW     = 4'b1000
  } bus_phase_t;

  // Outcome of one conversion and comparator update.
  typedef struct packed {
    logic [11:0] code;
    logic [2:0]  over_count;
    logic        alert;
  } conv_result_t;

  // Full-scale range in millivolts for a range code.
  function automatic logic [13:0] full_scale(input logic [2:0] range_code);
    logic [13:0] fsr;
    case (range_code)
      RANGE_6144: fsr = 14'd6144;
      RANGE_4096: fsr = 14'd4096;
      RANGE_2048: fsr = 14'd2048;
      RANGE_1024: fsr = 14'd1024;
      RANGE_512:  fsr = 14'd512;
      default:    fsr = 14'd256;
    endcase
    return fsr;
  endfunction

endpackage

>>> design/adcrd_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcrd_convert
// Conversion datapath: input selection, clamping to the full scale, scaling
// to a signed 12-bit code, and the traditional or window comparator.
// ----------------------------------------------------------------------------
module adcrd_convert (
  input  logic [15:0]                cfg,
  input  logic [15:0]                low_threshold,
  input  logic [15:0]                high_threshold,
  input  logic signed [13:0]         pin_a0,
  input  logic signed [13:0]         pin_a1,
  input  logic signed [13:0]         pin_a2,
  input  logic signed [13:0]         pin_a3,
  input  logic [2:0]                 over_count,
  input  logic                       alert_level,
  output adcrd_pkg::conv_result_t    result
);

  logic signed [14:0] a0_ext, a1_ext, a2_ext, a3_ext;
  logic signed [14:0] v_sel;
  logic signed [14:0] fsr_s;
  logic signed [14:0] v_clamp;
  logic        [14:0] neg_v;
  logic        [12:0] mag;
  logic        [25:0] prod;
  logic        [11:0] third;
  logic        [14:0] half_sum;
  logic        [11:0] code;
  logic signed [11:0] code_s, lo_s, hi_s;
  logic               above, below;
  logic        [2:0]  qlen;
  logic        [2:0]  cnt_inc;
  logic        [2:0]  cnt;
  logic               active;

  assign a0_ext = {pin_a0[13], pin_a0};
  assign a1_ext = {pin_a1[13], pin_a1};
  assign a2_ext = {pin_a2[13], pin_a2};
  assign a3_ext = {pin_a3[13], pin_a3};

  // Input multiplexer, single-ended or differential.
  always_comb begin
    case (cfg[14:12])
      adcrd_pkg::MUX_A0_A1: v_sel = a0_ext - a1_ext;
      adcrd_pkg::MUX_A0_A3: v_sel = a0_ext - a3_ext;
      adcrd_pkg::MUX_A1_A3: v_sel = a1_ext - a3_ext;
      adcrd_pkg::MUX_A2_A3: v_sel = a2_ext - a3_ext;
      adcrd_pkg::MUX_A0:    v_sel = a0_ext;
      adcrd_pkg::MUX_A1:    v_sel = a1_ext;
      adcrd_pkg::MUX_A2:    v_sel = a2_ext;
      default:              v_sel = a3_ext;
    endcase
  end

  // Clamp to [-fsr, fsr - 1].
  assign fsr_s = signed'({1'b0, adcrd_pkg::full_scale(cfg[11:9])});

  always_comb begin
    if (v_sel >= fsr_s) begin
      v_clamp = fsr_s - 15'sd1;
    end else if (v_sel < -fsr_s) begin
      v_clamp = -fsr_s;
    end else begin
      v_clamp = v_sel;
    end
  end

  // Division by three for the widest range works on the magnitude.
  assign neg_v    = -v_clamp;
  assign mag      = v_clamp[14] ? neg_v[12:0] : v_clamp[12:0];
  assign prod     = 26'(mag) * 26'(adcrd_pkg::RECIP_THIRD);
  assign third    = prod[25:14];
  // Halving rounds toward zero by adding one to negative values first.
  assign half_sum = v_clamp + {14'd0, v_clamp[14]};

  // Scale to 12 bits: code = v * 2048 / fsr, truncated toward zero.
  always_comb begin
    case (cfg[11:9])
      adcrd_pkg::RANGE_6144: code = v_clamp[14] ? (~third + 12'd1) : third;
      adcrd_pkg::RANGE_4096: code = half_sum[12:1];
      adcrd_pkg::RANGE_2048: code = v_clamp[11:0];
      adcrd_pkg::RANGE_1024: code = {v_clamp[10:0], 1'b0};
      adcrd_pkg::RANGE_512:  code = {v_clamp[9:0], 2'b0};
      default:               code = {v_clamp[8:0], 3'b0};
    endcase
  end

  // Comparator queue length.
  always_comb begin
    case (cfg[1:0])
      adcrd_pkg::QUEUE_ONE:  qlen = 3'd1;
      adcrd_pkg::QUEUE_TWO:  qlen = 3'd2;
      adcrd_pkg::QUEUE_FOUR: qlen = 3'd4;
      default:               qlen = 3'd0;
    endcase
  end

  assign code_s  = signed'(code);
  assign lo_s    = signed'(low_threshold[15:4]);
  assign hi_s    = signed'(high_threshold[15:4]);
  assign above   = code_s > hi_s;
  assign below   = code_s < lo_s;
  assign cnt_inc = over_count + 3'd1;
  assign active  = cfg[adcrd_pkg::CFG_POLARITY];

  // Over-threshold counter, window or hysteresis style, saturating at qlen.
  always_comb begin
    if (cfg[adcrd_pkg::CFG_WINDOW]) begin
      cnt = (above || below) ? cnt_inc : 3'd0;
    end else begin
      cnt = (above || over_count != 3'd0) ? cnt_inc : over_count;
      if (below) begin
        cnt = 3'd0;
      end
    end
    if (cnt > qlen) begin
      cnt = qlen;
    end
  end

  // Alert level; a disabled queue forces it inactive and keeps the counter.
  always_comb begin
    result.code = code;
    if (qlen == 3'd0) begin
      result.over_count = over_count;
      result.alert      = ~active;
    end else begin
      result.over_count = cnt;
      if (cnt >= qlen) begin
        result.alert = active;
      end else if (!cfg[adcrd_pkg::CFG_LATCH]) begin
        result.alert = ~active;
      end else begin
        result.alert = alert_level;
      end
    end
  end

endmodule

>>> design/adc_register_device_with_comparator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_register_device_with_comparator
// Byte-level register device of a 12-bit ADC with a window comparator.
// A transaction passes the input register, then the result register.
// Throughput: one transaction per cycle unless m_axis_tready holds a result;
// the state update and the conversion datapath sit in the one stage between.
// Reset (rst, synchronous): pipeline emptied, bus idle, registers to defaults.
// ----------------------------------------------------------------------------
module adc_register_device_with_comparator (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: data_byte[7:0], pin_a0[21:8], pin_a1[35:22], pin_a2[49:36],
  // pin_a3[63:50]
  input  logic [63:0] s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: read_byte[7:0], acked[8], alert_out[9], zeros[15:10]
  output logic [15:0] m_axis_tdata,
  // Configuration write channel: polling_mode.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  // Input register.
  logic        in_valid;
  logic [2:0]  in_kind;
  logic [7:0]  in_data;
  logic signed [13:0] in_a0, in_a1, in_a2, in_a3;

  // Result register.
  logic        out_valid;
  logic [15:0] out_data;

  // Device state.
  logic                  polling_mode;
  adcrd_pkg::bus_phase_t bus_phase, bus_phase_next;
  logic [1:0]  reg_pointer, reg_pointer_next;
  logic [15:0] conversion_reg, conversion_reg_next;
  logic [15:0] config_word, config_word_next;
  logic [15:0] low_threshold, low_threshold_next;
  logic [15:0] high_threshold, high_threshold_next;
  logic [2:0]  over_count, over_count_next;
  logic        alert_level, alert_level_next;

  // Item processing signals.
  logic        advance;
  logic [15:0] reg_cur;
  logic [15:0] wr_high, wr_low;
  logic        wr_en;
  logic [15:0] wr_val;
  logic [15:0] conv_cfg;
  logic        do_convert;
  logic [7:0]  rb;
  logic        ack;
  adcrd_pkg::conv_result_t conv_res;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign cfg_ready     = 1'b1;

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind <= s_axis_tuser;
      in_data <= s_axis_tdata[7:0];
      in_a0   <= s_axis_tdata[21:8];
      in_a1   <= s_axis_tdata[35:22];
      in_a2   <= s_axis_tdata[49:36];
      in_a3   <= s_axis_tdata[63:50];
    end
  end

  // Polling mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      polling_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      polling_mode <= cfg_data;
    end
  end

  // Register addressed by the pointer.
  always_comb begin
    case (reg_pointer)
      adcrd_pkg::PTR_CONVERSION: reg_cur = conversion_reg;
      adcrd_pkg::PTR_CONFIG:     reg_cur = config_word;
      adcrd_pkg::PTR_LOW_THRESH: reg_cur = low_threshold;
      default:                   reg_cur = high_threshold;
    endcase
  end

  assign wr_high = {in_data, reg_cur[7:0]};
  assign wr_low  = {reg_cur[15:8], in_data};

  // Bus phase machine and register access.
  always_comb begin
    bus_phase_next   = bus_phase;
    reg_pointer_next = reg_pointer;
    wr_en            = 1'b0;
    wr_val           = wr_high;
    conv_cfg         = config_word;
    do_convert       = 1'b0;
    rb               = 8'd0;
    ack              = 1'b0;
    alert_level_next = alert_level;
    case (in_kind)
      adcrd_pkg::KIND_START: begin
        if (bus_phase == adcrd_pkg::PH_IDLE) begin
          bus_phase_next = adcrd_pkg::PH_STARTED;
        end
        ack = 1'b1;
      end
      adcrd_pkg::KIND_STOP: begin
        bus_phase_next = adcrd_pkg::PH_IDLE;
        ack            = 1'b1;
      end
      adcrd_pkg::KIND_WRITE: begin
        case (bus_phase)
          adcrd_pkg::PH_STARTED: begin
            reg_pointer_next = in_data[1:0];
            bus_phase_next   = adcrd_pkg::PH_HIGH;
            ack              = 1'b1;
          end
          adcrd_pkg::PH_HIGH: begin
            wr_en          = 1'b1;
            wr_val         = wr_high;
            bus_phase_next = adcrd_pkg::PH_LOW;
            ack            = 1'b1;
          end
          adcrd_pkg::PH_LOW: begin
            wr_en          = 1'b1;
            wr_val         = wr_low;
            bus_phase_next = adcrd_pkg::PH_HIGH;
            ack            = 1'b1;
            // A completed config write may start a conversion.
            if (reg_pointer == adcrd_pkg::PTR_CONFIG) begin
              conv_cfg = wr_low;
              if (wr_low[adcrd_pkg::CFG_START]) begin
                wr_val     = {1'b0, wr_low[14:0]};
                do_convert = 1'b1;
              end else if (!polling_mode && !wr_low[adcrd_pkg::CFG_SINGLE]) begin
                do_convert = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      adcrd_pkg::KIND_READ: begin
        case (bus_phase)
          adcrd_pkg::PH_STARTED: begin
            rb             = {6'd0, reg_pointer};
            bus_phase_next = adcrd_pkg::PH_HIGH;
            ack            = 1'b1;
          end
          adcrd_pkg::PH_HIGH: begin
            rb             = reg_cur[15:8];
            bus_phase_next = adcrd_pkg::PH_LOW;
            ack            = 1'b1;
          end
          adcrd_pkg::PH_LOW: begin
            rb             = reg_cur[7:0];
            bus_phase_next = adcrd_pkg::PH_HIGH;
            ack            = 1'b1;
            // Reading the conversion result releases a latched alert.
            if (reg_pointer == adcrd_pkg::PTR_CONVERSION &&
                config_word[1:0] != adcrd_pkg::QUEUE_OFF &&
                config_word[adcrd_pkg::CFG_LATCH]) begin
              alert_level_next = ~config_word[adcrd_pkg::CFG_POLARITY];
            end
          end
          default: begin
          end
        endcase
      end
      adcrd_pkg::KIND_TICK: begin
        if (polling_mode && !config_word[adcrd_pkg::CFG_SINGLE]) begin
          do_convert = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Register writes, then the conversion outcome.
    conversion_reg_next = conversion_reg;
    config_word_next    = config_word;
    low_threshold_next  = low_threshold;
    high_threshold_next = high_threshold;
    over_count_next     = over_count;
    if (wr_en) begin
      case (reg_pointer)
        adcrd_pkg::PTR_CONVERSION: conversion_reg_next = wr_val;
        adcrd_pkg::PTR_CONFIG:     config_word_next    = wr_val;
        adcrd_pkg::PTR_LOW_THRESH: low_threshold_next  = wr_val;
        default:                   high_threshold_next = wr_val;
      endcase
    end
    if (do_convert) begin
      conversion_reg_next = {conv_res.code, conversion_reg[3:0]};
      over_count_next     = conv_res.over_count;
      alert_level_next    = conv_res.alert;
    end
  end

  adcrd_convert u_convert (
    .cfg            (conv_cfg),
    .low_threshold  (low_threshold),
    .high_threshold (high_threshold),
    .pin_a0         (in_a0),
    .pin_a1         (in_a1),
    .pin_a2         (in_a2),
    .pin_a3         (in_a3),
    .over_count     (over_count),
    .alert_level    (alert_level),
    .result         (conv_res)
  );

  // State update, one item per advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_phase      <= adcrd_pkg::PH_IDLE;
      reg_pointer    <= adcrd_pkg::PTR_CONVERSION;
      conversion_reg <= 16'd0;
      config_word    <= adcrd_pkg::CONFIG_RESET;
      low_threshold  <= adcrd_pkg::LOW_THR_RESET;
      high_threshold <= adcrd_pkg::HIGH_THR_RESET;
      over_count     <= 3'd0;
      alert_level    <= 1'b1;
    end else if (advance) begin
      bus_phase      <= bus_phase_next;
      reg_pointer    <= reg_pointer_next;
      conversion_reg <= conversion_reg_next;
      config_word    <= config_word_next;
      low_threshold  <= low_threshold_next;
      high_threshold <= high_threshold_next;
      over_count     <= over_count_next;
      alert_level    <= alert_level_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {6'd0, alert_level_next, ack, rb};
    end
  end

endmodule

>>> design/adcrd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcrd_checker
// Port-level checks of the ADC register device, bound to the top level.
// ----------------------------------------------------------------------------
module adcrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        cfg_ready
);

  // A stalled result transaction keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No result appears in the cycle after reset.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A transaction that is not acknowledged returns a zero byte.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("read byte returned without acknowledge");

  // Padding bits of the result stay zero and config is always taken.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0 && cfg_ready)
    else $error("padding bits set or config port not ready");

endmodule

bind adc_register_device_with_comparator adcrd_checker u_adcrd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready     (cfg_ready)
);
